// File: rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ASSERT_CLKD(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: rtl/jsu_pkg.sv
// types and constants of the json string unescaper
`default_nettype none

package jsu_pkg;

  // parser modes
  typedef enum logic [3:0] {
    MODE_IDLE = 4'd0,
    MODE_STR  = 4'd1,
    MODE_ESC  = 4'd2,
    MODE_HEX1 = 4'd3,
    MODE_BSL  = 4'd4,
    MODE_U    = 4'd5,
    MODE_HEX2 = 4'd6
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  // characters of the json string syntax
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // control bytes that the short escapes stand for
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0C;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_HT = 8'h09;

  // top six bits of high (d800..dbff) and low (dc00..dfff) surrogates
  localparam logic [5:0] SURR_HI_TAG = 6'h36;
  localparam logic [5:0] SURR_LO_TAG = 6'h37;

  // results of one input byte: up to four data bytes, then done or error
  typedef struct packed {
    logic [2:0]      n_data;
    logic [3:0][7:0] data;
    logic            has_tail;
    status_t         tail_st;
  } bundle_t;

endpackage

`default_nettype wire

// File: rtl/jsu_in_if.sv
// input byte channel
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// File: rtl/jsu_out_if.sv
// decoded result channel
`default_nettype none

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic       out_run_end;

  modport source (output valid, output out_byte, output out_status, output out_run_end,
                  input ready);
  modport sink (input valid, input out_byte, input out_status, input out_run_end,
                output ready);
endinterface

`default_nettype wire

// File: rtl/jsu_parser.sv
// escape parser: mode state and per-byte result bundle
`default_nettype none
`include "assert_macros.svh"

module jsu_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_last,
  output jsu_pkg::bundle_t     bundle
);

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } utf8_t;

  // utf-8 encoding of a code point up to 10ffff
  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r.b = '0;
    if (cp[20:7] == '0) begin
      r.n    = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp[20:11] == '0) begin
      r.n    = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp[20:16] == '0) begin
      r.n    = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.n    = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [15:0]    high_r, high_nxt;
  logic [15:0]    low_r, low_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  logic           hex_ok;
  logic [3:0]     hex_d;
  logic [15:0]    high_new;
  logic [15:0]    low_new;
  logic [20:0]    pair_cp;
  logic [20:0]    cp_sel;
  utf8_t          enc;
  logic           err;
  logic           emit_cp;

  // hex digit decode, either case
  always_comb begin
    hex_ok = 1'b1;
    hex_d  = '0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_d = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_d = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  // code point of the unit in progress, and of a surrogate pair
  assign high_new = {high_r[11:0], hex_d};
  assign low_new  = {low_r[11:0], hex_d};
  assign pair_cp  = {1'b0, high_r[9:0], low_new[9:0]} + 21'h10000;
  assign cp_sel   = (mode_r == jsu_pkg::MODE_HEX2) ? pair_cp : {5'b0, high_new};
  assign enc      = utf8_encode(cp_sel);

  // next mode and results of this byte
  always_comb begin
    mode_nxt        = mode_r;
    high_nxt        = high_r;
    low_nxt         = low_r;
    cnt_nxt         = cnt_r;
    err             = 1'b0;
    emit_cp         = 1'b0;
    bundle          = '0;
    bundle.tail_st  = jsu_pkg::ST_DATA;
    case (mode_r)
      jsu_pkg::MODE_STR: begin
        if (in_byte == jsu_pkg::CH_QUOTE) begin
          bundle.has_tail = 1'b1;
          bundle.tail_st  = jsu_pkg::ST_DONE;
          mode_nxt        = jsu_pkg::MODE_IDLE;
        end else if (in_byte == jsu_pkg::CH_BSL) begin
          mode_nxt = jsu_pkg::MODE_ESC;
        end else begin
          bundle.n_data  = 3'd1;
          bundle.data[0] = in_byte;
        end
      end
      jsu_pkg::MODE_ESC: begin
        mode_nxt       = jsu_pkg::MODE_STR;
        bundle.n_data  = 3'd1;
        case (in_byte)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: bundle.data[0] = in_byte;
          jsu_pkg::CH_B: bundle.data[0] = jsu_pkg::BYTE_BS;
          jsu_pkg::CH_F: bundle.data[0] = jsu_pkg::BYTE_FF;
          jsu_pkg::CH_N: bundle.data[0] = jsu_pkg::BYTE_LF;
          jsu_pkg::CH_R: bundle.data[0] = jsu_pkg::BYTE_CR;
          jsu_pkg::CH_T: bundle.data[0] = jsu_pkg::BYTE_HT;
          jsu_pkg::CH_U: begin
            bundle.n_data = 3'd0;
            mode_nxt      = jsu_pkg::MODE_HEX1;
            high_nxt      = '0;
            cnt_nxt       = '0;
          end
          default: begin
            bundle.n_data = 3'd0;
            err           = 1'b1;
          end
        endcase
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        if (!hex_ok) begin
          err = 1'b1;
        end else begin
          if (mode_r == jsu_pkg::MODE_HEX1) begin
            high_nxt = high_new;
          end else begin
            low_nxt = low_new;
          end
          if (cnt_r != 2'd3) begin
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            cnt_nxt = '0;
            if (mode_r == jsu_pkg::MODE_HEX1) begin
              if (high_new[15:10] == jsu_pkg::SURR_HI_TAG) begin
                mode_nxt = jsu_pkg::MODE_BSL;
              end else if (high_new[15:10] == jsu_pkg::SURR_LO_TAG) begin
                err = 1'b1;
              end else begin
                emit_cp  = 1'b1;
                mode_nxt = jsu_pkg::MODE_STR;
              end
            end else if (low_new[15:10] != jsu_pkg::SURR_LO_TAG) begin
              err = 1'b1;
            end else begin
              emit_cp  = 1'b1;
              mode_nxt = jsu_pkg::MODE_STR;
            end
          end
        end
        if (emit_cp) begin
          bundle.n_data = enc.n;
          bundle.data   = enc.b;
        end
      end
      jsu_pkg::MODE_BSL: begin
        if (in_byte == jsu_pkg::CH_BSL) begin
          mode_nxt = jsu_pkg::MODE_U;
        end else begin
          err = 1'b1;
        end
      end
      jsu_pkg::MODE_U: begin
        if (in_byte == jsu_pkg::CH_U) begin
          mode_nxt = jsu_pkg::MODE_HEX2;
          low_nxt  = '0;
          cnt_nxt  = '0;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        if (in_byte == jsu_pkg::CH_QUOTE) begin
          mode_nxt = jsu_pkg::MODE_STR;
        end else begin
          err = 1'b1;
        end
      end
    endcase

    // one error per byte: a fault, or text ending with the string open
    if (err || (in_last && mode_nxt != jsu_pkg::MODE_IDLE)) begin
      bundle.has_tail = 1'b1;
      bundle.tail_st  = jsu_pkg::ST_ERR;
      mode_nxt        = jsu_pkg::MODE_IDLE;
    end
    if (mode_nxt == jsu_pkg::MODE_IDLE) begin
      cnt_nxt = '0;
    end
  end

  // parser state, advanced on each input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_IDLE;
      high_r <= '0;
      low_r  <= '0;
      cnt_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  `ASSERT_CLKD(a_last_closes, clk, rst_n, (fire && in_last) |=> (mode_r == jsu_pkg::MODE_IDLE))
  `ASSERT_CLKD(a_idle_cnt_zero, clk, rst_n, (mode_r == jsu_pkg::MODE_IDLE) |-> (cnt_r == 2'd0))
  `ASSERT_CLKD(a_done_alone, clk, rst_n,
    (bundle.has_tail && bundle.tail_st == jsu_pkg::ST_DONE) |-> (bundle.n_data == 3'd0))

endmodule

`default_nettype wire

// File: rtl/jsu_serializer.sv
// result register that hands out one bundle entry per transaction
`default_nettype none
`include "assert_macros.svh"

module jsu_serializer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire jsu_pkg::bundle_t bundle_in,
  output logic                  in_ready,
  jsu_out_if.source             out_chan
);

  jsu_pkg::bundle_t bundle_r, bundle_nxt;
  logic             valid_r, valid_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic [2:0]       total_held;
  logic [2:0]       total_in;
  logic             is_last;
  logic             pop;
  logic             load;

  assign total_held = bundle_r.n_data + {2'b0, bundle_r.has_tail};
  assign total_in   = bundle_in.n_data + {2'b0, bundle_in.has_tail};
  assign is_last    = (idx_r + 3'd1) == total_held;
  assign pop        = valid_r && out_chan.ready;
  assign load       = fire && (total_in != 3'd0);
  assign in_ready   = !valid_r || (out_chan.ready && is_last);

  // current entry: data bytes first, then the done or error tail
  always_comb begin
    out_chan.valid       = valid_r;
    out_chan.out_run_end = is_last;
    if (idx_r < bundle_r.n_data) begin
      out_chan.out_byte   = bundle_r.data[idx_r[1:0]];
      out_chan.out_status = jsu_pkg::ST_DATA;
    end else begin
      out_chan.out_byte   = '0;
      out_chan.out_status = bundle_r.tail_st;
    end
  end

  // load a new bundle or step through the held one
  always_comb begin
    bundle_nxt = bundle_r;
    valid_nxt  = valid_r;
    idx_nxt    = idx_r;
    if (load) begin
      bundle_nxt = bundle_in;
      valid_nxt  = 1'b1;
      idx_nxt    = '0;
    end else if (pop && is_last) begin
      valid_nxt = 1'b0;
    end else if (pop) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bundle_r <= bundle_nxt;
  end

  `ASSERT_CLKD(a_idx_in_range, clk, rst_n, valid_r |-> (idx_r < total_held))
  `ASSERT_CLKD(a_step_holds, clk, rst_n,
    (pop && !is_last) |=> (valid_r && idx_r == $past(idx_r) + 3'd1))
  `ASSERT_ALWAYS(a_no_load_busy, clk, (load && rst_n) |-> in_ready)

endmodule

`default_nettype wire

// File: rtl/json_string_unescaper_utf8.sv
// json string unescaper: quoted json string in, utf-8 bytes and status out
// latency: first result of an input byte is offered in the cycle after its transaction
// throughput: one input byte per cycle while each byte gives at most one result and
//   the output is ready; a byte giving n results (up to 5: four utf-8 bytes and
//   an error) stalls the input until its last entry is out, one per output-ready cycle
// reset: synchronous active-low rst_n clears the parser to idle and empties the output
`default_nettype none

module json_string_unescaper_utf8 (
  input  wire logic clk,
  input  wire logic rst_n,
  jsu_in_if.sink    in_chan,
  jsu_out_if.source out_chan
);

  jsu_pkg::bundle_t bundle;
  logic             in_ready;
  logic             fire;

  assign in_chan.ready = in_ready;
  assign fire          = in_chan.valid && in_ready;

  // byte decode and parser state
  jsu_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (in_chan.in_byte),
    .in_last (in_chan.in_last),
    .bundle  (bundle)
  );

  // result register and output sequencing
  jsu_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .bundle_in (bundle),
    .in_ready  (in_ready),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire
